### sv/tcpa_pkg.sv
// ----------------------------------------------------------------------------
// tcpa_pkg
// Shared types and constants for the two-channel power accumulator: beat
// payload structs, converter channel codes and accumulator control.
// ----------------------------------------------------------------------------
package tcpa_pkg;

    // field widths
    localparam int SAMPLE_W = 10;
    localparam int CORR_W   = SAMPLE_W + 1;
    localparam int PROD_W   = 2 * CORR_W;
    localparam int SUM_W    = 32;
    localparam int COUNT_W  = 16;
    localparam int CHAN_W   = 2;

    // converter channel codes
    localparam logic [CHAN_W-1:0] CH_CURRENT1 = 2'd0;
    localparam logic [CHAN_W-1:0] CH_CURRENT2 = 2'd1;
    localparam logic [CHAN_W-1:0] CH_VOLTAGE  = 2'd2;

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // zero offset after reset
    localparam logic [SAMPLE_W-1:0] ZERO_OFFSET_RESET = 10'd510;

    // input beat
    typedef struct packed {
        logic                command;
        logic [SAMPLE_W-1:0] sample;
    } in_t;

    // window totals, in result order
    typedef struct packed {
        logic [SUM_W-1:0]   pos_sum_one;
        logic [SUM_W-1:0]   neg_sum_one;
        logic [COUNT_W-1:0] pos_count_one;
        logic [COUNT_W-1:0] neg_count_one;
        logic [SUM_W-1:0]   pos_sum_two;
        logic [SUM_W-1:0]   neg_sum_two;
        logic [COUNT_W-1:0] pos_count_two;
        logic [COUNT_W-1:0] neg_count_two;
    } totals_t;

    // result beat
    typedef struct packed {
        logic              window_valid;
        logic [CHAN_W-1:0] next_channel;
        totals_t           totals;
    } out_t;

    // accumulator control
    typedef struct packed {
        logic                     update;
        logic                     clear;
        logic                     chan;
        logic signed [PROD_W-1:0] product;
    } acc_cmd_t;

endpackage

### sv/tcpa_accum.sv
// ----------------------------------------------------------------------------
// tcpa_accum
// Window sums and counts for both channels. A non-negative product goes to
// the positive sum and count, a negative one adds its magnitude to the
// negative sum and count. Clear zeroes all eight totals.
// ----------------------------------------------------------------------------
module tcpa_accum (
    input  logic              aclk,
    input  logic              aresetn,
    input  tcpa_pkg::acc_cmd_t cmd,
    output tcpa_pkg::totals_t  totals
);
    import tcpa_pkg::*;

    // entry order: pos 1, neg 1, pos 2, neg 2
    logic [SUM_W-1:0]   sum_reg   [4];
    logic [SUM_W-1:0]   sum_next  [4];
    logic [COUNT_W-1:0] count_reg [4];
    logic [COUNT_W-1:0] count_next[4];

    logic                     is_neg;
    logic        [PROD_W-1:0] mag;
    logic        [1:0]        sel;

    // magnitude and target entry
    always_comb begin
        is_neg = cmd.product[PROD_W-1];
        mag    = is_neg ? PROD_W'(-cmd.product) : PROD_W'(cmd.product);
        sel    = {cmd.chan, is_neg};
    end

    // per-entry update
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (cmd.clear) begin
                sum_next[i]   = '0;
                count_next[i] = '0;
            end else if (cmd.update && (sel == 2'(i))) begin
                sum_next[i]   = sum_reg[i] + SUM_W'(mag);
                count_next[i] = count_reg[i] + COUNT_W'(1);
            end else begin
                sum_next[i]   = sum_reg[i];
                count_next[i] = count_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                sum_reg[i]   <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                sum_reg[i]   <= sum_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

    // totals out
    always_comb begin
        totals.pos_sum_one   = sum_reg[0];
        totals.neg_sum_one   = sum_reg[1];
        totals.pos_count_one = count_reg[0];
        totals.neg_count_one = count_reg[1];
        totals.pos_sum_two   = sum_reg[2];
        totals.neg_sum_two   = sum_reg[3];
        totals.pos_count_two = count_reg[2];
        totals.neg_count_two = count_reg[3];
    end

endmodule

### sv/two_channel_power_accumulator.sv
// ----------------------------------------------------------------------------
// two_channel_power_accumulator
// Power metering for two channels fed by one multiplexed converter.
// ----------------------------------------------------------------------------
// Input channel (s_valid/s_ready/s_data) carries either a converter result
// (command 0) or a window tick (command 1). Every input beat gives exactly
// one result beat on m_valid/m_ready/m_data.
// A converter result updates the stored voltage or, for a current sample,
// multiplies it by its channel's voltage and adds it to the window totals;
// the result carries the next converter channel and zero totals.
// A tick returns the eight window totals and clears them.
// A beat lands in the input register, then the result register, which
// drives m_valid and m_data. Throughput is one beat per cycle while the
// receiver keeps up; the multiply and add lie between the input and
// result registers.
// When the receiver stalls, the result register holds and the input
// register still takes one more beat; s_ready drops once both are full.
// cfg_we writes the zero offset; do so only while the block is idle.
// Reset (aresetn low, synchronous) clears totals and stored voltages,
// selects the voltage channel for channel 1 and sets the offset to 510.
// ----------------------------------------------------------------------------
module two_channel_power_accumulator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tcpa_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tcpa_pkg::out_t                    m_data,
    input  logic                              cfg_we,
    input  logic [tcpa_pkg::SAMPLE_W-1:0]     cfg_wdata
);
    import tcpa_pkg::*;

    logic [SAMPLE_W-1:0]      zero_offset_reg;
    logic [CHAN_W-1:0]        mux_sel_reg;
    logic [CHAN_W-1:0]        mux_sel_next;
    logic                     volt_tog_reg;
    logic                     volt_tog_next;
    logic signed [CORR_W-1:0] volt1_reg;
    logic signed [CORR_W-1:0] volt1_next;
    logic signed [CORR_W-1:0] volt2_reg;
    logic signed [CORR_W-1:0] volt2_next;
    logic                     in_valid_reg;
    in_t                      in_data_reg;
    logic                     out_valid_reg;
    out_t                     out_data_reg;
    out_t                     result;

    logic                     advance;
    logic                     is_tick;
    logic signed [CORR_W-1:0] corrected;
    logic signed [CORR_W-1:0] volt_sel;
    acc_cmd_t                 acc_cmd;
    totals_t                  totals;

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;
    assign is_tick = (in_data_reg.command == CMD_TICK);

    // offset correction and product
    always_comb begin
        corrected = $signed({1'b0, in_data_reg.sample}) - $signed({1'b0, zero_offset_reg});
        volt_sel  = (mux_sel_reg == CH_CURRENT2) ? volt2_reg : volt1_reg;
        acc_cmd.product = PROD_W'(corrected) * PROD_W'(volt_sel);
        acc_cmd.chan    = (mux_sel_reg == CH_CURRENT2);
        acc_cmd.clear   = advance && is_tick;
        acc_cmd.update  = advance && !is_tick &&
                          ((mux_sel_reg == CH_CURRENT1) || (mux_sel_reg == CH_CURRENT2));
    end

    // channel sequencing and stored voltages
    always_comb begin
        mux_sel_next  = mux_sel_reg;
        volt_tog_next = volt_tog_reg;
        volt1_next    = volt1_reg;
        volt2_next    = volt2_reg;
        case (mux_sel_reg)
            CH_CURRENT1, CH_CURRENT2: begin
                mux_sel_next = CH_VOLTAGE;
            end
            CH_VOLTAGE: begin
                if (volt_tog_reg) begin
                    volt2_next   = corrected;
                    mux_sel_next = CH_CURRENT2;
                end else begin
                    volt1_next   = corrected;
                    mux_sel_next = CH_CURRENT1;
                end
                volt_tog_next = !volt_tog_reg;
            end
            default: begin
                mux_sel_next = mux_sel_reg;
            end
        endcase
    end

    // result beat
    always_comb begin
        result.window_valid = is_tick;
        result.next_channel = is_tick ? mux_sel_reg : mux_sel_next;
        result.totals       = is_tick ? totals : '0;
    end

    tcpa_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (acc_cmd),
        .totals  (totals)
    );

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_offset_reg <= ZERO_OFFSET_RESET;
            mux_sel_reg     <= CH_VOLTAGE;
            volt_tog_reg    <= 1'b0;
            volt1_reg       <= '0;
            volt2_reg       <= '0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                zero_offset_reg <= cfg_wdata;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance && !is_tick) begin
                mux_sel_reg  <= mux_sel_next;
                volt_tog_reg <= volt_tog_next;
                volt1_reg    <= volt1_next;
                volt2_reg    <= volt2_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule

### tb/power_meter_monitor.sv
// ----------------------------------------------------------------------------
// power_meter_monitor
// Watches both beat channels and the zero-offset write port of the power
// accumulator, keeps its own copy of the meter state, predicts the result
// beat for every accepted input beat and compares each result beat field by
// field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module power_meter_monitor
    import tcpa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  in_t                 s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  out_t                m_data,
    input  logic                cfg_we,
    input  logic [SAMPLE_W-1:0] cfg_wdata,
    output int                  mismatch_count,
    output int                  pending_results,
    output int                  results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // total slots, same order as in the result beat
    localparam int POS_ONE = 0;
    localparam int NEG_ONE = 1;
    localparam int POS_TWO = 2;
    localparam int NEG_TWO = 3;

    // predicted meter state
    logic [SAMPLE_W-1:0]      offset_q;
    logic [CHAN_W-1:0]        select_q;
    logic                     voltage_two_next;
    logic signed [CORR_W-1:0] voltage_q [2];
    logic [SUM_W-1:0]         sum_q [4];
    logic [COUNT_W-1:0]       count_q [4];

    // predicted result beats still waiting for the block
    out_t expected_results [$];

    // multiply a current by its channel's voltage and book it by sign
    function automatic void book_power(input int chan,
                                       input logic signed [CORR_W-1:0] current);
        logic signed [PROD_W-1:0] product;
        logic [PROD_W-1:0]        magnitude;
        int                       slot;
        product   = current * voltage_q[chan];
        magnitude = (product < 0) ? -product : product;
        slot      = 2 * chan + ((product < 0) ? 1 : 0);
        sum_q[slot]   = sum_q[slot] + SUM_W'(magnitude);
        count_q[slot] = count_q[slot] + 1'b1;
    endfunction

    // result beat for one input beat, updating the predicted state
    function automatic out_t meter_result(input in_t beat);
        out_t                     result;
        logic signed [CORR_W-1:0] corrected;
        result    = '0;
        corrected = $signed({1'b0, beat.sample}) - $signed({1'b0, offset_q});
        if (beat.command == CMD_TICK) begin
            result.window_valid         = 1'b1;
            result.next_channel         = select_q;
            result.totals.pos_sum_one   = sum_q[POS_ONE];
            result.totals.neg_sum_one   = sum_q[NEG_ONE];
            result.totals.pos_count_one = count_q[POS_ONE];
            result.totals.neg_count_one = count_q[NEG_ONE];
            result.totals.pos_sum_two   = sum_q[POS_TWO];
            result.totals.neg_sum_two   = sum_q[NEG_TWO];
            result.totals.pos_count_two = count_q[POS_TWO];
            result.totals.neg_count_two = count_q[NEG_TWO];
            for (int i = 0; i < 4; i++) begin
                sum_q[i]   = '0;
                count_q[i] = '0;
            end
        end else begin
            case (select_q)
                CH_CURRENT1: begin
                    book_power(0, corrected);
                    select_q = CH_VOLTAGE;
                end
                CH_CURRENT2: begin
                    book_power(1, corrected);
                    select_q = CH_VOLTAGE;
                end
                CH_VOLTAGE: begin
                    if (voltage_two_next) begin
                        voltage_q[1]     = corrected;
                        select_q         = CH_CURRENT2;
                        voltage_two_next = 1'b0;
                    end else begin
                        voltage_q[0]     = corrected;
                        select_q         = CH_CURRENT1;
                        voltage_two_next = 1'b1;
                    end
                end
                default: begin
                    // unused selection holds
                end
            endcase
            result.next_channel = select_q;
        end
        return result;
    endfunction

    function automatic string beat_text(input out_t beat);
        return $sformatf("wv=%0d ch=%0d c1 +%0h/%0d -%0h/%0d c2 +%0h/%0d -%0h/%0d",
                         beat.window_valid, beat.next_channel,
                         beat.totals.pos_sum_one, beat.totals.pos_count_one,
                         beat.totals.neg_sum_one, beat.totals.neg_count_one,
                         beat.totals.pos_sum_two, beat.totals.pos_count_two,
                         beat.totals.neg_sum_two, beat.totals.neg_count_two);
    endfunction

    task automatic flag_result(input string what, input out_t want, input out_t got);
        if (mismatch_count < MAX_REPORTS) begin
            $display("[%0t] result beat %0d: %s", $realtime, results_checked, what);
            $display("    expected %s", beat_text(want));
            $display("    actual   %s", beat_text(got));
        end
        mismatch_count++;
    endtask

    // track state, predict on input beats, compare on result beats
    always @(posedge aclk) begin : track
        out_t want;
        if (!aresetn) begin
            offset_q         = ZERO_OFFSET_RESET;
            select_q         = CH_VOLTAGE;
            voltage_two_next = 1'b0;
            voltage_q[0]     = '0;
            voltage_q[1]     = '0;
            for (int i = 0; i < 4; i++) begin
                sum_q[i]   = '0;
                count_q[i] = '0;
            end
            expected_results.delete();
        end else begin
            // result beat against the oldest prediction
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_results.size() == 0) begin
                    flag_result("no result was due", '0, m_data);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.window_valid !== want.window_valid ||
                        m_data.next_channel !== want.next_channel ||
                        m_data.totals.pos_sum_one !== want.totals.pos_sum_one ||
                        m_data.totals.neg_sum_one !== want.totals.neg_sum_one ||
                        m_data.totals.pos_count_one !== want.totals.pos_count_one ||
                        m_data.totals.neg_count_one !== want.totals.neg_count_one ||
                        m_data.totals.pos_sum_two !== want.totals.pos_sum_two ||
                        m_data.totals.neg_sum_two !== want.totals.neg_sum_two ||
                        m_data.totals.pos_count_two !== want.totals.pos_count_two ||
                        m_data.totals.neg_count_two !== want.totals.neg_count_two) begin
                        flag_result("field mismatch", want, m_data);
                    end
                end
            end
            // zero offset write
            if (cfg_we) begin
                offset_q = cfg_wdata;
            end
            // input beat
            if (s_valid && s_ready) begin
                expected_results.push_back(meter_result(s_data));
            end
        end
        pending_results = expected_results.size();
    end

endmodule

### tb/two_channel_power_accumulator_test.sv
// ----------------------------------------------------------------------------
// two_channel_power_accumulator_test
// Drives the power accumulator with converter samples and window ticks:
// a directed pass over offset and sample extremes, then random phases with
// a new zero offset each, random idling on both channels and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module two_channel_power_accumulator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tcpa_pkg::*;

    localparam int CYCLE_LIMIT     = 100_000;
    localparam int IDLE_PCT        = 27;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASES          = 6;
    localparam int PHASE_BEATS     = 300;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_t                 s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_t                m_data;
    logic                cfg_we    = 1'b0;
    logic [SAMPLE_W-1:0] cfg_wdata = '0;

    int                  mismatch_count;
    int                  pending_results;
    int                  results_checked;

    // stimulus bookkeeping
    logic                calm = 1'b0;
    logic [SAMPLE_W-1:0] zero_code = ZERO_OFFSET_RESET;
    int                  stall_requests = 0;
    int                  stalls_done = 0;
    int                  hold_left = 0;
    int                  cycle_count = 0;
    int                  beats_sent = 0;
    int                  ticks_sent = 0;
    int                  offsets_written = 0;

    always #4 aclk = ~aclk;

    two_channel_power_accumulator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    power_meter_monitor meter_monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    // run length guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random idling, long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stall_requests != stalls_done) begin
            m_ready     <= 1'b0;
            hold_left   <= HOLD_OFF_CYCLES;
            stalls_done <= stalls_done + 1;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // offer one input beat and wait for it to be taken; valid stays up
    task automatic send_beat(input logic cmd, input logic [SAMPLE_W-1:0] value);
        in_t beat;
        beat.command = cmd;
        beat.sample  = value;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        if (cmd == CMD_TICK) begin
            ticks_sent++;
        end
    endtask

    // drain the block, then write the zero offset
    task automatic set_offset(input logic [SAMPLE_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        zero_code = value;
        offsets_written++;
    endtask

    initial begin
        logic [SAMPLE_W-1:0] value;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset offset: empty window, both product signs, zero voltage
        send_beat(CMD_TICK,   10'h3FF);
        send_beat(CMD_SAMPLE, 10'd1023);
        send_beat(CMD_SAMPLE, 10'd0);
        send_beat(CMD_SAMPLE, 10'd0);
        send_beat(CMD_SAMPLE, 10'd0);
        send_beat(CMD_SAMPLE, 10'd510);
        send_beat(CMD_SAMPLE, 10'd1023);
        send_beat(CMD_SAMPLE, 10'd1023);
        send_beat(CMD_SAMPLE, 10'd510);
        send_beat(CMD_TICK,   10'd0);
        send_beat(CMD_TICK,   10'h155);
        // tick between a voltage and its current
        send_beat(CMD_SAMPLE, 10'h2AA);
        send_beat(CMD_TICK,   10'h2AA);
        send_beat(CMD_SAMPLE, 10'h155);

        // offset zero: largest positive product
        set_offset(10'd0);
        send_beat(CMD_SAMPLE, 10'd1023);
        send_beat(CMD_SAMPLE, 10'd1023);
        send_beat(CMD_SAMPLE, 10'd0);
        send_beat(CMD_SAMPLE, 10'd1023);
        send_beat(CMD_TICK,   10'd0);

        // offset at top: both samples at the negative end
        set_offset(10'd1023);
        send_beat(CMD_SAMPLE, 10'd0);
        send_beat(CMD_SAMPLE, 10'd0);
        send_beat(CMD_SAMPLE, 10'd1023);
        send_beat(CMD_SAMPLE, 10'd0);
        send_beat(CMD_SAMPLE, 10'd0);
        send_beat(CMD_SAMPLE, 10'd1023);
        send_beat(CMD_TICK,   10'h3FF);

        // random phases, each under its own offset
        for (int phase = 0; phase < PHASES; phase++) begin
            set_offset(10'($urandom_range(1023)));
            calm = (phase == 2);
            if (phase == 4) begin
                stall_requests++;
            end
            repeat (PHASE_BEATS) begin
                case ($urandom_range(7))
                    0: value = '0;
                    1: value = '1;
                    2: value = zero_code;
                    3: value = zero_code + 10'($urandom_range(4)) - 10'd2;
                    default: value = 10'($urandom_range(1023));
                endcase
                send_beat(($urandom_range(15) == 0) ? CMD_TICK : CMD_SAMPLE, value);
            end
            calm = 1'b0;
        end

        // drain and settle
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("sent %0d beats (%0d window ticks) under %0d offset writes",
                 beats_sent, ticks_sent, offsets_written);
        $display("checked %0d result beats, %0d mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
sv/tcpa_pkg.sv
sv/tcpa_accum.sv
sv/two_channel_power_accumulator.sv
tb/power_meter_monitor.sv
tb/two_channel_power_accumulator_test.sv
